@@ sv/ioc_pkg.sv @@
// ioc_pkg: shared types and constants of the I/O controller register block.
// Used by ioc_ctrl, ioc_datapath and io_controller_with_bcd_clock.
// No dependencies.
`default_nettype none

package ioc_pkg;

  localparam int unsigned CLOCK_BYTES = 32;
  localparam int unsigned CLOCK_IDX_W = $clog2(CLOCK_BYTES);
  localparam int unsigned TICKS_PER_HUNDREDTH_DEF = 10;
  localparam int unsigned ADDR_W = 14;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Word addresses (byte offset / 4).
  localparam logic [ADDR_W-CLOCK_IDX_W-1:0] WA_CLOCK_PAGE = 9'h01c;
  localparam logic [ADDR_W-1:0] WA_BOARD_ID   = 14'h0017;
  localparam logic [ADDR_W-1:0] WA_PAR_PTR    = 14'h002b;
  localparam logic [ADDR_W-1:0] WA_REV_ID     = 14'h0030;
  localparam logic [ADDR_W-1:0] WA_MISC       = 14'h006c;
  localparam logic [ADDR_W-1:0] WA_LMASK0     = 14'h0071;
  localparam logic [ADDR_W-1:0] WA_LMASK1     = 14'h0073;
  localparam logic [ADDR_W-1:0] WA_VMASK0     = 14'h0075;
  localparam logic [ADDR_W-1:0] WA_VMASK1     = 14'h0076;
  localparam logic [ADDR_W-1:0] WA_SER_CTL_A  = 14'h0340;
  localparam logic [ADDR_W-1:0] WA_SER_CTL_B  = 14'h0342;
  localparam logic [ADDR_W-1:0] WA_SER_STUB_LO = 14'h0344;
  localparam logic [ADDR_W-1:0] WA_SER_STUB_HI = 14'h034f;
  localparam logic [ADDR_W-1:0] WA_SER_ST0    = 14'h0344;
  localparam logic [ADDR_W-1:0] WA_SER_ST1    = 14'h0348;
  localparam logic [ADDR_W-1:0] WA_SER_ST2    = 14'h034c;

  localparam logic [DATA_W-1:0] BOARD_ID_WORD = 32'h0000a500;
  localparam logic [DATA_W-1:0] REV_ID_WORD   = 32'h0000001f;
  localparam logic [DATA_W-1:0] SER_CTL_WORD  = 32'h0000007c;
  localparam logic [DATA_W-1:0] SER_ST_WORD   = 32'h00000004;

  localparam logic [CLOCK_IDX_W-1:0] CB_CTRL    = 5'd0;
  localparam logic [CLOCK_IDX_W-1:0] CB_CMD     = 5'd4;
  localparam logic [CLOCK_IDX_W-1:0] CB_HUND    = 5'd5;
  localparam logic [CLOCK_IDX_W-1:0] CB_SEC     = 5'd6;
  localparam logic [CLOCK_IDX_W-1:0] CB_MIN     = 5'd7;
  localparam logic [CLOCK_IDX_W-1:0] CB_HOUR    = 5'd8;
  localparam logic [CLOCK_IDX_W-1:0] CB_DAY     = 5'd9;
  localparam int unsigned LATCH_SRC   = 6;
  localparam int unsigned LATCH_DST   = 25;
  localparam int unsigned LATCH_BYTES = 5;

  typedef struct packed {
    logic capture;
    logic exec;
  } ioc_cmd_t;

endpackage

`default_nettype wire

@@ sv/io_controller_with_bcd_clock.sv @@
// io_controller_with_bcd_clock: top level of the I/O controller register block.
// Depends on ioc_pkg, ioc_ctrl and ioc_datapath.
//
//   channel   handshake          payload
//   request   start_i / busy_o   command_i, word_address_i, write_data_i
//   response  done_o (strobe)    read_data_o, unmapped_o
//
// Each transaction steps through accept, execute (one read-modify-write
// of the flop registers), then done_o for one cycle. busy_o is high from
// the cycle after accept until the response cycle ends; a new transaction
// is accepted in the cycle after done_o. Reset is asynchronous, active low,
// and clears all but the captured request. The receiver cannot stall.
`default_nettype none

module io_controller_with_bcd_clock
  import ioc_pkg::*;
#(
  parameter int unsigned TicksPerHundredth = TICKS_PER_HUNDREDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [ADDR_W-1:0] word_address_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  output logic                   done_o,
  output logic      [DATA_W-1:0] read_data_o,
  output logic                   unmapped_o
);

  ioc_cmd_t cmd;

  ioc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  ioc_datapath #(
    .TicksPerHundredth (TicksPerHundredth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .command_i      (command_i),
    .word_address_i (word_address_i),
    .write_data_i   (write_data_i),
    .read_data_o    (read_data_o),
    .unmapped_o     (unmapped_o)
  );

endmodule

`default_nettype wire

@@ sv/ioc_ctrl.sv @@
// ioc_ctrl: transaction sequencer, idle -> execute -> respond.
// Depends on ioc_pkg; drives ioc_datapath through ioc_cmd_t.
`default_nettype none

module ioc_ctrl
  import ioc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  output logic          done_o,
  output ioc_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_RESP);
  assign cmd_o.capture = (state_q == ST_IDLE) && start_i;
  assign cmd_o.exec    = (state_q == ST_EXEC);

endmodule

`default_nettype wire

@@ sv/ioc_datapath.sv @@
// ioc_datapath: register file, clock store, BCD clock advance and read mux.
// Depends on ioc_pkg; sequenced by ioc_ctrl.
`default_nettype none

module ioc_datapath
  import ioc_pkg::*;
#(
  parameter int unsigned TicksPerHundredth = TICKS_PER_HUNDREDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ioc_cmd_t          cmd_i,
  input  wire logic [1:0]        command_i,
  input  wire logic [ADDR_W-1:0] word_address_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  output logic      [DATA_W-1:0] read_data_o,
  output logic                   unmapped_o
);

  function automatic logic [8:0] bcd_bump(input logic [7:0] b);
    logic [7:0] v;
    v = b + 8'd1;
    if (v[3:0] == 4'ha) begin
      return {1'b1, v + 8'h06};
    end
    return {1'b0, v};
  endfunction

  cmd_e              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;

  logic [7:0] store_q [CLOCK_BYTES];
  logic [7:0] store_d [CLOCK_BYTES];
  logic [3:0] presc_q, presc_d;
  logic [7:0] misc_q, misc_d;
  logic [DATA_W-1:0] pptr_q, pptr_d, lm0_q, lm0_d, lm1_q, lm1_d, vm0_q, vm0_d, vm1_q, vm1_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic              unmap_q, unmap_d;

  logic                   in_clock;
  logic [CLOCK_IDX_W-1:0] idx;
  logic [3:0]             presc_inc;
  logic [8:0]             b_hund, b_sec, b_min, b_hour;
  logic                   roll_hund, roll_sec, roll_min, roll_hour;

  assign in_clock  = (addr_q[ADDR_W-1:CLOCK_IDX_W] == WA_CLOCK_PAGE);
  assign idx       = addr_q[CLOCK_IDX_W-1:0];
  assign presc_inc = presc_q + 4'd1;
  assign b_hund    = bcd_bump(store_q[CB_HUND]);
  assign b_sec     = bcd_bump(store_q[CB_SEC]);
  assign b_min     = bcd_bump(store_q[CB_MIN]);
  assign b_hour    = bcd_bump(store_q[CB_HOUR]);
  assign roll_hund = b_hund[8] && ((b_hund[7:0] & 8'ha0) == 8'ha0);
  assign roll_sec  = b_sec[8] && (b_sec[7:0] == 8'h60);
  assign roll_min  = b_min[8] && (b_min[7:0] == 8'h60);
  assign roll_hour = (b_hour[7:0] == 8'h24);

  always_comb begin
    store_d = store_q;
    presc_d = presc_q;
    misc_d  = misc_q;
    pptr_d  = pptr_q;
    lm0_d   = lm0_q;
    lm1_d   = lm1_q;
    vm0_d   = vm0_q;
    vm1_d   = vm1_q;
    rdata_d = rdata_q;
    unmap_d = unmap_q;
    if (cmd_i.exec) begin
      rdata_d = '0;
      unmap_d = 1'b0;
      unique case (op_q)
        CMD_READ: begin
          if (in_clock) begin
            rdata_d = {24'd0, store_q[idx]};
          end else begin
            unique case (addr_q)
              WA_BOARD_ID:  rdata_d = BOARD_ID_WORD;
              WA_PAR_PTR:   rdata_d = pptr_q;
              WA_REV_ID:    rdata_d = REV_ID_WORD;
              WA_MISC:      rdata_d = {24'd0, misc_q};
              WA_LMASK0:    rdata_d = lm0_q;
              WA_LMASK1:    rdata_d = lm1_q;
              WA_VMASK0:    rdata_d = vm0_q;
              WA_VMASK1:    rdata_d = vm1_q;
              WA_SER_CTL_A,
              WA_SER_CTL_B: rdata_d = SER_CTL_WORD;
              WA_SER_ST0,
              WA_SER_ST1,
              WA_SER_ST2:   rdata_d = SER_ST_WORD;
              default: begin
                if (addr_q < WA_SER_STUB_LO || addr_q > WA_SER_STUB_HI) begin
                  unmap_d = 1'b1;
                end
              end
            endcase
          end
        end
        CMD_WRITE: begin
          if (in_clock) begin
            store_d[idx] = wdata_q[7:0];
            if (idx == CB_CMD && !store_q[CB_CTRL][7] && wdata_q[7]) begin
              for (int i = 0; i < LATCH_BYTES; i++) begin
                store_d[LATCH_DST+i] = store_q[LATCH_SRC+i];
              end
            end
          end else begin
            unique case (addr_q)
              WA_PAR_PTR: pptr_d = wdata_q;
              WA_MISC:    misc_d = wdata_q[7:0];
              WA_LMASK0:  lm0_d  = wdata_q;
              WA_LMASK1:  lm1_d  = wdata_q;
              WA_VMASK0:  vm0_d  = wdata_q;
              WA_VMASK1:  vm1_d  = wdata_q;
              default: begin
                if (addr_q < WA_SER_STUB_LO || addr_q > WA_SER_STUB_HI) begin
                  unmap_d = 1'b1;
                end
              end
            endcase
          end
        end
        CMD_TICK: begin
          presc_d = presc_inc;
          if (presc_inc >= 4'(TicksPerHundredth)) begin
            presc_d = 4'd0;
            if (!roll_hund) begin
              store_d[CB_HUND] = b_hund[7:0];
            end else begin
              store_d[CB_HUND] = 8'd0;
              if (!roll_sec) begin
                store_d[CB_SEC] = b_sec[7:0];
              end else begin
                store_d[CB_SEC] = 8'd0;
                if (!roll_min) begin
                  store_d[CB_MIN] = b_min[7:0];
                end else begin
                  store_d[CB_MIN] = 8'd0;
                  if (roll_hour) begin
                    store_d[CB_HOUR] = 8'd0;
                    store_d[CB_DAY]  = store_q[CB_DAY] + 8'd1;
                  end else begin
                    store_d[CB_HOUR] = b_hour[7:0];
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= cmd_e'(command_i);
      addr_q  <= word_address_i;
      wdata_q <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLOCK_BYTES; i++) begin
        store_q[i] <= 8'd0;
      end
      presc_q <= '0;
      misc_q  <= '0;
      pptr_q  <= '0;
      lm0_q   <= '0;
      lm1_q   <= '0;
      vm0_q   <= '0;
      vm1_q   <= '0;
      rdata_q <= '0;
      unmap_q <= 1'b0;
    end else begin
      store_q <= store_d;
      presc_q <= presc_d;
      misc_q  <= misc_d;
      pptr_q  <= pptr_d;
      lm0_q   <= lm0_d;
      lm1_q   <= lm1_d;
      vm0_q   <= vm0_d;
      vm1_q   <= vm1_d;
      rdata_q <= rdata_d;
      unmap_q <= unmap_d;
    end
  end

  assign read_data_o = rdata_q;
  assign unmapped_o  = unmap_q;

endmodule

`default_nettype wire
